[rtl/core/grid_neighbor_rank_unit_macros.svh]
// Assertion macros for the grid neighbour rank unit.
`ifndef GRID_NEIGHBOR_RANK_UNIT_MACROS_SVH
`define GRID_NEIGHBOR_RANK_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GNR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GNR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GNR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GNR_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/gnr_pkg.sv]
package gnr_pkg;

  localparam int MAX_DIMS = 4;
  localparam int DIM_W    = 2;
  localparam int RANK_W   = 32;
  localparam int AXIS_W   = 11;
  localparam int COORD_W  = 10;
  localparam int STRIDE_W = 31;
  localparam int NDIMS_W  = 3;
  localparam int CNT_W    = 6;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [AXIS_W-1:0]  AXIS_MAX       = 11'd1024;
  localparam logic [AXIS_W-1:0]  AXIS_RESET     = 11'd1;
  localparam logic [NDIMS_W-1:0] NUM_DIMS_RESET = 3'd3;
  localparam logic [CNT_W-1:0]   DIV_STEPS      = CNT_W'(RANK_W);

  typedef enum logic [2:0] {
    REG_NUM_DIMS = 3'd0,
    REG_AXIS_0   = 3'd1,
    REG_AXIS_1   = 3'd2,
    REG_AXIS_2   = 3'd3,
    REG_AXIS_3   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NDIMS_W-1:0]               num_dims;
    logic [MAX_DIMS-1:0][AXIS_W-1:0]  axis_size;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] dividend;
    logic [AXIS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RANK_W-1:0]  quotient;
    logic [COORD_W-1:0] remainder;
  } div_rsp_t;

  // index of the highest dimension in use
  function automatic logic [DIM_W-1:0] eff_last_dim(input logic [NDIMS_W-1:0] num_dims);
    logic [DIM_W-1:0] res;
    if (num_dims == '0) begin
      res = '0;
    end else if (num_dims > NDIMS_W'(MAX_DIMS)) begin
      res = DIM_W'(MAX_DIMS - 1);
    end else begin
      res = DIM_W'(num_dims - NDIMS_W'(1));
    end
    return res;
  endfunction

  function automatic logic [AXIS_W-1:0] eff_axis(input logic [AXIS_W-1:0] raw);
    logic [AXIS_W-1:0] res;
    if (raw == '0) begin
      res = AXIS_W'(1);
    end else if (raw > AXIS_MAX) begin
      res = AXIS_MAX;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

[rtl/core/gnr_regs.sv]
module gnr_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gnr_pkg::ADDR_W-1:0] paddr,
  input  logic [gnr_pkg::DATA_W-1:0] pwdata,
  output logic [gnr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gnr_pkg::cfg_t              cfg
);

  logic [gnr_pkg::NDIMS_W-1:0]                         num_dims;
  logic [gnr_pkg::MAX_DIMS-1:0][gnr_pkg::AXIS_W-1:0]   axis_size;
  gnr_pkg::reg_idx_t                                   idx;
  logic                                                wr_en;

  assign pready = 1'b1;
  assign idx    = gnr_pkg::reg_idx_t'(paddr[gnr_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= gnr_pkg::NUM_DIMS_RESET;
      for (int i = 0; i < gnr_pkg::MAX_DIMS; i++) begin
        axis_size[i] <= gnr_pkg::AXIS_RESET;
      end
    end else if (wr_en) begin
      case (idx)
        gnr_pkg::REG_NUM_DIMS: num_dims     <= pwdata[gnr_pkg::NDIMS_W-1:0];
        gnr_pkg::REG_AXIS_0:   axis_size[0] <= pwdata[gnr_pkg::AXIS_W-1:0];
        gnr_pkg::REG_AXIS_1:   axis_size[1] <= pwdata[gnr_pkg::AXIS_W-1:0];
        gnr_pkg::REG_AXIS_2:   axis_size[2] <= pwdata[gnr_pkg::AXIS_W-1:0];
        gnr_pkg::REG_AXIS_3:   axis_size[3] <= pwdata[gnr_pkg::AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gnr_pkg::REG_NUM_DIMS: prdata = gnr_pkg::DATA_W'(num_dims);
      gnr_pkg::REG_AXIS_0:   prdata = gnr_pkg::DATA_W'(axis_size[0]);
      gnr_pkg::REG_AXIS_1:   prdata = gnr_pkg::DATA_W'(axis_size[1]);
      gnr_pkg::REG_AXIS_2:   prdata = gnr_pkg::DATA_W'(axis_size[2]);
      gnr_pkg::REG_AXIS_3:   prdata = gnr_pkg::DATA_W'(axis_size[3]);
      default:               prdata = '0;
    endcase
  end

  assign cfg.num_dims  = num_dims;
  assign cfg.axis_size = axis_size;

endmodule

[rtl/core/gnr_div.sv]
// Restoring divider, one quotient bit per cycle.
module gnr_div (
  input  logic              clk,
  input  logic              rst,
  input  gnr_pkg::div_req_t req,
  output gnr_pkg::div_rsp_t rsp
);

  logic [gnr_pkg::RANK_W-1:0] quo;
  logic [gnr_pkg::AXIS_W-1:0] rem;
  logic [gnr_pkg::AXIS_W-1:0] dvs;
  logic [gnr_pkg::CNT_W-1:0]  cnt;
  logic                       running;
  logic                       done;
  logic [gnr_pkg::AXIS_W:0]   shifted;
  logic [gnr_pkg::AXIS_W+1:0] diff;

  assign shifted = {rem, quo[gnr_pkg::RANK_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= gnr_pkg::DIV_STEPS;
      end else if (running) begin
        cnt <= cnt - gnr_pkg::CNT_W'(1);
        if (cnt == gnr_pkg::CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (running) begin
      // trial subtract; shifted stays below twice the divisor
      if (!diff[gnr_pkg::AXIS_W+1]) begin
        rem <= diff[gnr_pkg::AXIS_W-1:0];
        quo <= {quo[gnr_pkg::RANK_W-2:0], 1'b1};
      end else begin
        rem <= shifted[gnr_pkg::AXIS_W-1:0];
        quo <= {quo[gnr_pkg::RANK_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[gnr_pkg::COORD_W-1:0];

endmodule

[rtl/core/gnr_ctrl.sv]
module gnr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  gnr_pkg::cfg_t               cfg,
  input  logic                        start,
  output logic                        busy,
  input  logic [gnr_pkg::RANK_W-1:0]  node_rank,
  output gnr_pkg::div_req_t           div_req,
  input  gnr_pkg::div_rsp_t           div_rsp,
  output logic                        strobe,
  output logic                        direction,
  output logic [gnr_pkg::DIM_W-1:0]   dimension,
  output logic [gnr_pkg::COORD_W-1:0] own_coord,
  output logic                        neighbor_valid,
  output logic [gnr_pkg::RANK_W-1:0]  neighbor_rank,
  output logic                        rank_error,
  output logic                        last
);

  gnr_pkg::state_t state, state_next;

  logic [gnr_pkg::RANK_W-1:0]                          rank;
  logic [gnr_pkg::RANK_W-1:0]                          rest;
  logic [gnr_pkg::MAX_DIMS-1:0][gnr_pkg::COORD_W-1:0]  coord;
  logic [gnr_pkg::MAX_DIMS-1:0][gnr_pkg::STRIDE_W-1:0] stride;
  logic [gnr_pkg::DIM_W-1:0]                           dim;
  logic                                                dir;
  logic                                                err;

  logic [gnr_pkg::DIM_W-1:0]                   last_dim;
  logic [gnr_pkg::AXIS_W-1:0]                  axis_cur;
  logic [gnr_pkg::STRIDE_W+gnr_pkg::AXIS_W-1:0] prod_full;
  logic [gnr_pkg::RANK_W:0]                    sum_up;
  logic [gnr_pkg::RANK_W-1:0]                  diff_dn;
  logic [gnr_pkg::AXIS_W-1:0]                  coord_inc;
  logic                                        ok_up;
  logic                                        ok_dn;
  logic                                        is_last_dim;
  logic                                        do_div;
  logic                                        do_emit;

  assign last_dim    = gnr_pkg::eff_last_dim(cfg.num_dims);
  assign axis_cur    = gnr_pkg::eff_axis(cfg.axis_size[dim]);
  assign is_last_dim = (dim == last_dim);

  assign prod_full = {{gnr_pkg::AXIS_W{1'b0}}, stride[dim]} *
                     {{gnr_pkg::STRIDE_W{1'b0}}, axis_cur};

  assign sum_up    = {1'b0, rank} + {2'b00, stride[dim]};
  assign diff_dn   = rank - {1'b0, stride[dim]};
  assign coord_inc = {1'b0, coord[dim]} + gnr_pkg::AXIS_W'(1);
  // a carry out means the neighbour rank does not fit
  assign ok_up = !err && (coord_inc < axis_cur) && !sum_up[gnr_pkg::RANK_W];
  assign ok_dn = !err && (coord[dim] != '0);

  always_comb begin
    state_next = state;
    case (state)
      gnr_pkg::ST_IDLE:     if (start) state_next = gnr_pkg::ST_DIV_GO;
      gnr_pkg::ST_DIV_GO:   state_next = gnr_pkg::ST_DIV_WAIT;
      gnr_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = is_last_dim ? gnr_pkg::ST_EMIT : gnr_pkg::ST_DIV_GO;
        end
      end
      gnr_pkg::ST_EMIT:     if (dir && is_last_dim) state_next = gnr_pkg::ST_IDLE;
      default:              state_next = gnr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    do_div  = 1'b0;
    do_emit = 1'b0;
    case (state)
      gnr_pkg::ST_IDLE:   busy    = 1'b0;
      gnr_pkg::ST_DIV_GO: do_div  = 1'b1;
      gnr_pkg::ST_EMIT:   do_emit = 1'b1;
      default: ;
    endcase
  end

  assign div_req.start    = do_div;
  assign div_req.dividend = rest;
  assign div_req.divisor  = axis_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gnr_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= do_emit;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == gnr_pkg::ST_IDLE) && start) begin
      rank      <= node_rank;
      rest      <= node_rank;
      dim       <= '0;
      dir       <= 1'b0;
      stride[0] <= gnr_pkg::STRIDE_W'(1);
    end else if ((state == gnr_pkg::ST_DIV_WAIT) && div_rsp.done) begin
      coord[dim] <= div_rsp.remainder;
      rest       <= div_rsp.quotient;
      if (is_last_dim) begin
        // anything left above the top digit means rank >= grid product
        err <= (div_rsp.quotient != '0);
        dim <= '0;
      end else begin
        stride[dim + gnr_pkg::DIM_W'(1)] <= prod_full[gnr_pkg::STRIDE_W-1:0];
        dim <= dim + gnr_pkg::DIM_W'(1);
      end
    end else if (do_emit) begin
      direction      <= dir;
      dimension      <= dim;
      own_coord      <= err ? '0 : coord[dim];
      rank_error     <= err;
      last           <= dir && is_last_dim;
      neighbor_valid <= dir ? ok_dn : ok_up;
      if (dir) begin
        neighbor_rank <= ok_dn ? diff_dn : '0;
      end else begin
        neighbor_rank <= ok_up ? sum_up[gnr_pkg::RANK_W-1:0] : '0;
      end
      if (is_last_dim) begin
        dim <= '0;
        dir <= 1'b1;
      end else begin
        dim <= dim + gnr_pkg::DIM_W'(1);
      end
    end
  end

endmodule

[rtl/core/grid_neighbor_rank_unit.sv]
// Neighbour ranks of a node on a non-periodic Cartesian grid of up to four
// dimensions.
// Configuration: APB registers num_dims (0x00) and axis_size_0..3
// (0x04..0x10); write only while busy is low.
// Request: node_rank is taken at a clock edge with start high and busy low.
// busy then stays high until the last result has been issued.
// Results: 2*D results (D = dimensions in use), +1 neighbours for dimensions
// 0 upward, then -1 neighbours; each is held for one cycle with strobe high,
// last marks the final one. The receiver cannot stall, so nothing is held.
// Operation: one division per dimension on a shared bit-serial divider of
// 32 steps; the results follow the last division, then one result per cycle.
// The single divider serves one request at a time, so no new request is
// taken while one is in flight. A new request is taken in the cycle that
// shows the last result.
// Reset (rst, synchronous): registers return to num_dims = 3, all axis sizes
// 1; any request in flight is dropped and no further results appear.
`include "grid_neighbor_rank_unit_macros.svh"

module grid_neighbor_rank_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gnr_pkg::ADDR_W-1:0]  paddr,
  input  logic [gnr_pkg::DATA_W-1:0]  pwdata,
  output logic [gnr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [gnr_pkg::RANK_W-1:0]  node_rank,
  output logic                        strobe,
  output logic                        direction,
  output logic [gnr_pkg::DIM_W-1:0]   dimension,
  output logic [gnr_pkg::COORD_W-1:0] own_coord,
  output logic                        neighbor_valid,
  output logic [gnr_pkg::RANK_W-1:0]  neighbor_rank,
  output logic                        rank_error,
  output logic                        last
);

  gnr_pkg::cfg_t     cfg;
  gnr_pkg::div_req_t div_req;
  gnr_pkg::div_rsp_t div_rsp;

  gnr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gnr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gnr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .start          (start),
    .busy           (busy),
    .node_rank      (node_rank),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .strobe         (strobe),
    .direction      (direction),
    .dimension      (dimension),
    .own_coord      (own_coord),
    .neighbor_valid (neighbor_valid),
    .neighbor_rank  (neighbor_rank),
    .rank_error     (rank_error),
    .last           (last)
  );

  `GNR_ASSERT_NXT(a_req_busy, clk, rst, start && !busy, busy, "request did not raise busy")
  `GNR_ASSERT_IMP(a_last_idle, clk, rst, strobe && last, !busy, "busy after last result")
  `GNR_ASSERT_IMP(a_more_busy, clk, rst, strobe && !last, busy, "idle before last result")
  `GNR_ASSERT_IMP(a_err_inval, clk, rst, strobe && rank_error, !neighbor_valid && own_coord == '0,
                  "neighbour flagged on rank error")
  `GNR_ASSERT_IMP(a_inval_zero, clk, rst, strobe && !neighbor_valid, neighbor_rank == '0,
                  "invalid neighbour with nonzero rank")

endmodule

[verif/grid_neighbor_rank_unit_checker.sv]
`timescale 1ns / 100ps

module neighbour_rank_checker
  import gnr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                start,
  input  logic                busy,
  input  logic [RANK_W-1:0]   node_rank,
  input  logic                strobe,
  input  logic                direction,
  input  logic [DIM_W-1:0]    dimension,
  input  logic [COORD_W-1:0]  own_coord,
  input  logic                neighbor_valid,
  input  logic [RANK_W-1:0]   neighbor_rank,
  input  logic                rank_error,
  input  logic                last,
  output int unsigned         failures,
  output int unsigned         outstanding
);

  typedef struct packed {
    logic               direction;
    logic [DIM_W-1:0]   dimension;
    logic [COORD_W-1:0] own_coord;
    logic               neighbor_valid;
    logic [RANK_W-1:0]  neighbor_rank;
    logic               rank_error;
    logic               last;
  } neighbour_t;

  logic [NDIMS_W-1:0] grid_dims;
  logic [AXIS_W-1:0]  grid_axis [MAX_DIMS];
  neighbour_t         pending_neighbours [$];

  function automatic longint unsigned axis_extent(input logic [AXIS_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 1024) return 1024;
    return raw;
  endfunction

  function automatic string describe_neighbour(input neighbour_t n);
    return $sformatf("dir %0d dim %0d coord %0d valid %0b rank %h err %0b last %0b",
                     n.direction, n.dimension, n.own_coord, n.neighbor_valid,
                     n.neighbor_rank, n.rank_error, n.last);
  endfunction

  // Mixed-radix split of the rank, then +1 neighbours for every dimension,
  // then -1 neighbours.
  task automatic predict_neighbours(input logic [RANK_W-1:0] rank);
    longint unsigned extent [MAX_DIMS];
    longint unsigned coord [MAX_DIMS];
    longint unsigned stride [MAX_DIMS];
    longint unsigned volume;
    longint unsigned rest;
    longint unsigned nb;
    int unsigned     nd;
    int unsigned     d;
    int unsigned     pass;
    bit              err;
    bit              ok;
    neighbour_t      item;
    nd = grid_dims;
    if (nd == 0) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    volume = 1;
    rest = rank;
    for (d = 0; d < nd; d++) begin
      extent[d] = axis_extent(grid_axis[d]);
      stride[d] = volume;
      volume = volume * extent[d];
      coord[d] = rest % extent[d];
      rest = rest / extent[d];
    end
    err = rank >= volume;
    for (pass = 0; pass < 2; pass++) begin
      for (d = 0; d < nd; d++) begin
        nb = 0;
        ok = 1'b0;
        if (!err) begin
          if (pass == 0) begin
            if (coord[d] + 1 < extent[d]) begin
              nb = rank + stride[d];
              // only reachable when the grid spans more than 2^32 nodes
              ok = nb <= 64'hFFFF_FFFF;
            end
          end else if (coord[d] > 0) begin
            nb = rank - stride[d];
            ok = 1'b1;
          end
        end
        if (!ok) nb = 0;
        item.direction      = (pass == 1);
        item.dimension      = DIM_W'(d);
        item.own_coord      = err ? '0 : COORD_W'(coord[d]);
        item.neighbor_valid = ok;
        item.neighbor_rank  = nb[RANK_W-1:0];
        item.rank_error     = err;
        item.last           = (pass == 1) && (d == nd - 1);
        pending_neighbours = {pending_neighbours, item};
      end
    end
  endtask

  always @(posedge clk) begin
    neighbour_t seen;
    neighbour_t want;
    if (rst) begin
      grid_dims = NUM_DIMS_RESET;
      for (int i = 0; i < MAX_DIMS; i++) grid_axis[i] = AXIS_RESET;
      failures = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] == REG_NUM_DIMS) begin
          grid_dims = pwdata[NDIMS_W-1:0];
        end else if (paddr[4:2] >= REG_AXIS_0 && paddr[4:2] <= REG_AXIS_3) begin
          grid_axis[DIM_W'(paddr[4:2] - REG_AXIS_0)] = pwdata[AXIS_W-1:0];
        end
      end
      if (strobe) begin
        seen.direction      = direction;
        seen.dimension      = dimension;
        seen.own_coord      = own_coord;
        seen.neighbor_valid = neighbor_valid;
        seen.neighbor_rank  = neighbor_rank;
        seen.rank_error     = rank_error;
        seen.last           = last;
        if (pending_neighbours.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no request pending: %s", $time,
                     describe_neighbour(seen));
        end else begin
          want = pending_neighbours.pop_front();
          if (seen !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: neighbour mismatch", $time);
              $display("  expected %s", describe_neighbour(want));
              $display("  actual   %s", describe_neighbour(seen));
            end
          end
        end
      end
      // a request can be taken in the same cycle as the last result
      if (start && !busy) predict_neighbours(node_rank);
    end
    outstanding = pending_neighbours.size();
  end

endmodule

[verif/grid_neighbor_rank_unit_tb.sv]
`timescale 1ns / 100ps

module grid_neighbor_rank_unit_tb;
  import gnr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0]  UNUSED_REG  = 3'd5;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [RANK_W-1:0]   node_rank = '0;
  logic                strobe;
  logic                direction;
  logic [DIM_W-1:0]    dimension;
  logic [COORD_W-1:0]  own_coord;
  logic                neighbor_valid;
  logic [RANK_W-1:0]   neighbor_rank;
  logic                rank_error;
  logic                last;
  int unsigned         failures;
  int unsigned         outstanding;
  int unsigned         cycles = 0;

  // stimulus-side copy of the grid, used only to aim ranks at it
  logic [NDIMS_W-1:0]  cur_dims = NUM_DIMS_RESET;
  logic [AXIS_W-1:0]   cur_axis [MAX_DIMS] = '{default: AXIS_RESET};
  bit                  quiet = 1'b0;

  grid_neighbor_rank_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .node_rank(node_rank),
    .strobe(strobe), .direction(direction), .dimension(dimension),
    .own_coord(own_coord), .neighbor_valid(neighbor_valid),
    .neighbor_rank(neighbor_rank), .rank_error(rank_error), .last(last)
  );

  neighbour_rank_checker u_rank_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .start(start), .busy(busy), .node_rank(node_rank),
    .strobe(strobe), .direction(direction), .dimension(dimension),
    .own_coord(own_coord), .neighbor_valid(neighbor_valid),
    .neighbor_rank(neighbor_rank), .rank_error(rank_error), .last(last),
    .failures(failures), .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint unsigned grid_volume();
    longint unsigned vol;
    longint unsigned ext;
    int unsigned     nd;
    nd = cur_dims;
    if (nd == 0) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    vol = 1;
    for (int d = 0; d < nd; d++) begin
      ext = cur_axis[d];
      if (ext == 0) ext = 1;
      if (ext > 1024) ext = 1024;
      vol = vol * ext;
    end
    return vol;
  endfunction

  function automatic logic [AXIS_W-1:0] draw_axis();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return AXIS_W'($urandom_range(1, 12));
    if (roll < 9) return AXIS_W'($urandom_range(0, 2047));
    return AXIS_MAX;
  endfunction

  // mostly ranks on the grid, some just past it and some anywhere
  function automatic logic [RANK_W-1:0] pick_rank();
    int unsigned     roll;
    longint unsigned vol;
    roll = $urandom_range(0, 9);
    vol = grid_volume();
    if (roll == 0 || vol > 64'hFFFF_FFFF) return $urandom;
    if (roll == 1) return vol[RANK_W-1:0];
    if (roll == 2) return RANK_W'(vol - 1);
    return RANK_W'({$urandom, $urandom} % vol);
  endfunction

  // back-to-back APB writes; psel stays up between them
  task automatic program_grid(input logic [NDIMS_W-1:0] dims,
                              input logic [AXIS_W-1:0] a0, input logic [AXIS_W-1:0] a1,
                              input logic [AXIS_W-1:0] a2, input logic [AXIS_W-1:0] a3,
                              input bit poke_unused);
    logic [DATA_W-1:0] words [6];
    logic [2:0]        idx [6];
    int                n;
    for (int i = 0; i < 6; i++) words[i] = $urandom;
    words[0][NDIMS_W-1:0] = dims;
    words[1][AXIS_W-1:0]  = a0;
    words[2][AXIS_W-1:0]  = a1;
    words[3][AXIS_W-1:0]  = a2;
    words[4][AXIS_W-1:0]  = a3;
    idx[0] = REG_NUM_DIMS;
    idx[1] = REG_AXIS_0;
    idx[2] = REG_AXIS_1;
    idx[3] = REG_AXIS_2;
    idx[4] = REG_AXIS_3;
    idx[5] = UNUSED_REG;
    n = poke_unused ? 6 : 5;
    for (int i = 0; i < n; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= words[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_dims    = dims;
    cur_axis[0] = a0;
    cur_axis[1] = a1;
    cur_axis[2] = a2;
    cur_axis[3] = a3;
  endtask

  // start is left high so a zero gap gives a back-to-back request
  task automatic send_rank(input logic [RANK_W-1:0] r);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    node_rank <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (busy || outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int p;
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset grid: 3 dimensions of extent 1, a single node
    send_rank(32'd0);
    send_rank(32'd1);
    send_rank(32'hFFFF_FFFF);
    settle();

    // largest grid, wider than 32 bits of rank
    program_grid(3'd4, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b0);
    send_rank(32'd0);
    send_rank(32'hFFFF_FFFF);
    send_rank(32'h3FFF_FFFF);
    send_rank(32'h4000_0000);
    settle();

    // zero dimensions behaves as one
    program_grid(3'd0, 11'd9, 11'd0, 11'd0, 11'd0, 1'b0);
    send_rank(32'd0);
    send_rank(32'd4);
    send_rank(32'd8);
    send_rank(32'd9);
    settle();

    // dimensions above four clamp, oversize and zero extents clamp
    program_grid(3'd7, 11'd2047, 11'd0, 11'd1025, 11'd3, 1'b0);
    send_rank(32'd0);
    send_rank(32'h002F_FFFF);
    send_rank(32'h0030_0000);
    send_rank(32'h0018_0401);
    settle();

    // small 2-D grid; the write past the last register must change nothing
    program_grid(3'd2, 11'd3, 11'd4, 11'd1, 11'd1, 1'b1);
    send_rank(32'd0);
    send_rank(32'd5);
    send_rank(32'd11);
    send_rank(32'd12);
    send_rank(32'd7);
    settle();

    program_grid(3'd1, AXIS_MAX, 11'd1, 11'd1, 11'd1, 1'b0);
    send_rank(32'd1023);
    send_rank(32'd1024);
    send_rank(32'd512);
    settle();

    for (p = 0; p < 8; p++) begin
      quiet = (p % 3 == 2);
      program_grid(NDIMS_W'($urandom_range(0, 7)), draw_axis(), draw_axis(),
                   draw_axis(), draw_axis(), 1'b0);
      for (i = 0; i < 15; i++) send_rank(pick_rank());
      settle();
    end

    repeat (200) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
